/* src/bp2l_pkg.sv */
// Shared types, constants and helper functions of the two-level branch predictor.
// Depends on nothing; bp2l_index and the top level refer to it by scoped names, the testbench files import it.
`timescale 1ns / 1ps

package bp2l_pkg;

	// Sizing
	localparam int BTB_ENTRIES = 32;
	localparam int HIST_MAX    = 8;

	localparam int IDX_W     = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
	localparam bit IDX_POW2  = ((1 << IDX_W) == BTB_ENTRIES);
	localparam int ROW_SIZE  = 1 << HIST_MAX;
	localparam int ROW_W     = $clog2(BTB_ENTRIES + 1);
	localparam int CTR_DEPTH = (BTB_ENTRIES + 1) * ROW_SIZE;
	localparam int CTR_AW    = $clog2(CTR_DEPTH);

	localparam int PC_W      = 32;
	localparam int CFG_W     = 4;
	localparam int HLEN_W    = 4;

	// Remainder unit: the word index is split into digits of this many bits
	localparam int IDX_DIGIT   = 8;
	localparam int IDX_STEPS   = PC_W / IDX_DIGIT;
	localparam int IDX_STEP_W  = $clog2(IDX_STEPS);

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [HIST_MAX-1:0] hist_t;
	typedef logic [1:0]          ctr_t;
	typedef logic [HLEN_W-1:0]   hlen_t;

	localparam ctr_t  CTR_SNT = 2'b00;
	localparam ctr_t  CTR_WNT = 2'b01;
	localparam ctr_t  CTR_ST  = 2'b11;
	localparam logic [PC_W-1:0] PC_STEP = 32'd4;
	localparam hlen_t HLEN_RESET = 4'd8;

	typedef enum logic [1:0] {
		FUNC_PREDICT = 2'd0,
		FUNC_SET     = 2'd1,
		FUNC_UPDATE  = 2'd2,
		FUNC_NONE    = 2'd3
	} func_e;

	typedef enum logic [1:0] {
		CFG_GLOBAL_HISTORY = 2'd0,
		CFG_GLOBAL_TABLE   = 2'd1,
		CFG_SHARE_INDEX    = 2'd2,
		CFG_HISTORY_LENGTH = 2'd3
	} cfg_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INDEX,
		ST_ENTRY,
		ST_COUNTER,
		ST_FILL,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [PC_W-1:0] tag;
		logic [PC_W-1:0] target;
		hist_t           hist;
	} entry_t;

	typedef struct packed {
		logic done;
		idx_t idx;
	} idx_resp_t;

	// History mask for a length register; zero acts as one, overlong as HIST_MAX
	function automatic hist_t hist_mask(input hlen_t len);
		hlen_t n;
		hist_t m;
		n = len;
		if (n == '0)
			n = hlen_t'(1);
		if (n > hlen_t'(HIST_MAX))
			n = hlen_t'(HIST_MAX);
		for (int i = 0; i < HIST_MAX; i++)
			m[i] = (i < int'(n));
		return m;
	endfunction

endpackage

/* src/bp2l_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module bp2l_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* src/bp2l_index.sv */
// Buffer index unit: (pc >> 2) modulo the entry count.
// Depends on bp2l_pkg. A power-of-two count is a bit slice; otherwise a digit-serial remainder.
`timescale 1ns / 1ps

module bp2l_index (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [bp2l_pkg::PC_W-1:0]      pc,
	output bp2l_pkg::idx_resp_t            resp
);

	logic done_q;

	generate
		if (bp2l_pkg::IDX_POW2) begin : g_slice
			bp2l_pkg::idx_t idx_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					done_q <= 1'b0;
				else if (start)
					done_q <= 1'b1;
			end

			always_ff @(posedge clk) begin
				if (start)
					idx_q <= pc[2 +: bp2l_pkg::IDX_W];
			end

			assign resp.idx = idx_q;
		end else begin : g_rem
			localparam logic [bp2l_pkg::IDX_W:0] MOD = (bp2l_pkg::IDX_W + 1)'(bp2l_pkg::BTB_ENTRIES);

			logic [bp2l_pkg::PC_W-1:0]       word_q;
			bp2l_pkg::idx_t                  rem_q;
			logic [bp2l_pkg::IDX_STEP_W-1:0] step_q;
			logic                            busy_q;
			logic [bp2l_pkg::IDX_W:0]        r;

			// Fold one digit into the running remainder, most significant bit first
			always_comb begin
				r = {1'b0, rem_q};
				for (int i = 0; i < bp2l_pkg::IDX_DIGIT; i++) begin
					r = {r[bp2l_pkg::IDX_W-1:0], word_q[bp2l_pkg::PC_W-1-i]};
					if (r >= MOD)
						r = r - MOD;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
					busy_q <= 1'b0;
					step_q <= '0;
				end else if (start) begin
					done_q <= 1'b0;
					busy_q <= 1'b1;
					step_q <= '0;
				end else if (busy_q) begin
					step_q <= step_q + 1'b1;
					if (&step_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					word_q <= {2'b00, pc[bp2l_pkg::PC_W-1:2]};
					rem_q  <= '0;
				end else if (busy_q) begin
					word_q <= word_q << bp2l_pkg::IDX_DIGIT;
					rem_q  <= r[bp2l_pkg::IDX_W-1:0];
				end
			end

			assign resp.idx = rem_q;
		end
	endgenerate

	assign resp.done = done_q;

endmodule

/* src/branch_predictor_btb_two_level.sv */
// Top level of the two-level branch predictor with its branch target buffer.
// Depends on bp2l_pkg, bp2l_index and bp2l_ram.
`timescale 1ns / 1ps

// A direct-mapped branch target buffer of BTB_ENTRIES entries, indexed by pc bits above
// bit 1, with 2-bit saturating direction counters selected by a local or global history
// and held in per-entry rows or one shared table (optionally XOR-folded with the index).
// Every transfer on the input channel yields exactly one result transfer. The block works
// on one item at a time: the entry memory is read, then the counter memory, and each is
// written back before the next item starts, so no forwarding is needed. A predict hit or
// an update hit passes through a counter state for the registered read of the counter
// memory; a predict miss, an update miss, a set branch and the unused function code go
// from the entry state straight to the result state. A non-power-of-two entry count adds
// the steps of the digit-serial index remainder unit. The counter memory has no reset;
// a valid bit per counter row (one row per entry and one for the shared table) makes an
// untouched row read as weakly not taken. The first update that writes a row after
// reset, or after set branch reallocated the entry, sweeps the whole row of 2^HIST_MAX
// counters (256) before the result. A finished result waits in an output register; the
// next item is taken as soon as the result has been loaded there, so the input side can
// take and work on one further item while the output side stalls. The configuration port
// takes writes at any time but must only be used while the block is idle.
module branch_predictor_btb_two_level (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic [bp2l_pkg::PC_W-1:0]         pc,
	input  logic [bp2l_pkg::PC_W-1:0]         target_pc,
	input  logic                              taken,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic                              predict_taken,
	output logic [bp2l_pkg::PC_W-1:0]         next_pc,
	// configuration
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [bp2l_pkg::CFG_W-1:0]        cfg_wdata
);

	// configuration registers
	logic                   global_history_q;
	logic                   global_table_q;
	logic                   share_index_q;
	bp2l_pkg::hlen_t        history_length_q;

	// control state
	bp2l_pkg::state_t       state_q, state_d;
	logic                   out_valid_q;
	logic [bp2l_pkg::BTB_ENTRIES-1:0] ent_valid_q;
	logic [bp2l_pkg::BTB_ENTRIES:0]   row_valid_q;
	bp2l_pkg::hist_t        shared_hist_q;

	// item held for the duration of its work
	bp2l_pkg::func_e        func_q;
	logic [bp2l_pkg::PC_W-1:0] pc_q;
	logic [bp2l_pkg::PC_W-1:0] target_q;
	logic                   taken_q;

	// values carried from the entry read to the counter stage
	logic                   hit_q;
	logic                   pred_q;
	logic [bp2l_pkg::PC_W-1:0] ent_target_q;
	bp2l_pkg::row_t         ctr_row_q;
	bp2l_pkg::hist_t        ctr_h_q;
	bp2l_pkg::ctr_t         ctr_new_q;
	bp2l_pkg::hist_t        fill_q;

	// result register
	logic                   hit_out_q;
	logic                   pred_out_q;
	logic [bp2l_pkg::PC_W-1:0] next_pc_q;

	// index unit
	logic                   idx_start;
	bp2l_pkg::idx_resp_t    idx_resp;

	// memory ports
	logic                   ent_re, ent_we;
	bp2l_pkg::entry_t       ent_wdata, ent_rdata;
	logic                   ctr_re, ctr_we;
	logic [bp2l_pkg::CTR_AW-1:0] ctr_raddr, ctr_waddr;
	bp2l_pkg::ctr_t         ctr_wdata, ctr_rdata;

	// datapath
	logic                   in_xfer;
	bp2l_pkg::entry_t       ent;
	logic                   hit_c;
	logic                   need_ctr;
	bp2l_pkg::hist_t        hmask;
	bp2l_pkg::hist_t        hist_raw;
	bp2l_pkg::hist_t        hist_next;
	bp2l_pkg::hist_t        idx_h;
	bp2l_pkg::hist_t        h_sample;
	logic [bp2l_pkg::PC_W-1:0] idx_ext;
	bp2l_pkg::row_t         row_c;
	logic                   row_ok;
	bp2l_pkg::ctr_t         ctr_cur;
	bp2l_pkg::ctr_t         ctr_upd;
	logic                   fill_last;
	logic                   out_load;

	assign in_ready = (state_q == bp2l_pkg::ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	assign out_valid     = out_valid_q;
	assign hit           = hit_out_q;
	assign predict_taken = pred_out_q;
	assign next_pc       = next_pc_q;

	bp2l_index u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (idx_start),
		.pc     (pc),
		.resp   (idx_resp)
	);

	bp2l_ram #(
		.WIDTH ($bits(bp2l_pkg::entry_t)),
		.DEPTH (bp2l_pkg::BTB_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (idx_resp.idx),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (idx_resp.idx),
		.rdata (ent_rdata)
	);

	bp2l_ram #(
		.WIDTH ($bits(bp2l_pkg::ctr_t)),
		.DEPTH (bp2l_pkg::CTR_DEPTH)
	) u_counter_ram (
		.clk   (clk),
		.we    (ctr_we),
		.waddr (ctr_waddr),
		.wdata (ctr_wdata),
		.re    (ctr_re),
		.raddr (ctr_raddr),
		.rdata (ctr_rdata)
	);

	// Entry stage: an entry never written since reset reads as all zero
	always_comb begin
		ent      = ent_valid_q[idx_resp.idx] ? ent_rdata : '0;
		hit_c    = (ent.tag == pc_q);
		need_ctr = hit_c && ((func_q == bp2l_pkg::FUNC_PREDICT) ||
		                     (func_q == bp2l_pkg::FUNC_UPDATE));
		hmask    = bp2l_pkg::hist_mask(history_length_q);
		hist_raw = global_history_q ? shared_hist_q : ent.hist;
		hist_next = {hist_raw[bp2l_pkg::HIST_MAX-2:0], taken_q} & hmask;
		idx_ext  = bp2l_pkg::PC_W'(idx_resp.idx);
		idx_h    = idx_ext[bp2l_pkg::HIST_MAX-1:0];
		h_sample = hist_raw & hmask;
		if (global_table_q && share_index_q)
			h_sample = h_sample ^ (idx_h & hmask);
		row_c    = global_table_q ? bp2l_pkg::row_t'(bp2l_pkg::BTB_ENTRIES)
		                          : bp2l_pkg::row_t'(idx_resp.idx);
	end

	// Counter stage: an invalid row reads as weakly not taken
	always_comb begin
		row_ok    = row_valid_q[ctr_row_q];
		ctr_cur   = row_ok ? ctr_rdata : bp2l_pkg::CTR_WNT;
		if (taken_q)
			ctr_upd = (ctr_cur == bp2l_pkg::CTR_ST) ? ctr_cur : ctr_cur + 2'd1;
		else
			ctr_upd = (ctr_cur == bp2l_pkg::CTR_SNT) ? ctr_cur : ctr_cur - 2'd1;
		fill_last = &fill_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bp2l_pkg::ST_IDLE: begin
				if (in_xfer)
					state_d = bp2l_pkg::ST_INDEX;
			end
			bp2l_pkg::ST_INDEX: begin
				if (idx_resp.done)
					state_d = bp2l_pkg::ST_ENTRY;
			end
			bp2l_pkg::ST_ENTRY: begin
				state_d = need_ctr ? bp2l_pkg::ST_COUNTER : bp2l_pkg::ST_RESULT;
			end
			bp2l_pkg::ST_COUNTER: begin
				if ((func_q == bp2l_pkg::FUNC_UPDATE) && !row_ok)
					state_d = bp2l_pkg::ST_FILL;
				else
					state_d = bp2l_pkg::ST_RESULT;
			end
			bp2l_pkg::ST_FILL: begin
				if (fill_last)
					state_d = bp2l_pkg::ST_RESULT;
			end
			bp2l_pkg::ST_RESULT: begin
				if (!out_valid_q || out_ready)
					state_d = bp2l_pkg::ST_IDLE;
			end
			default: state_d = bp2l_pkg::ST_IDLE;
		endcase
	end

	// Memory and unit controls per state
	always_comb begin
		idx_start = 1'b0;
		ent_re    = 1'b0;
		ent_we    = 1'b0;
		ent_wdata = '0;
		ctr_re    = 1'b0;
		ctr_raddr = {row_c, h_sample};
		ctr_we    = 1'b0;
		ctr_waddr = {ctr_row_q, ctr_h_q};
		ctr_wdata = ctr_upd;
		out_load  = 1'b0;
		unique case (state_q)
			bp2l_pkg::ST_IDLE: begin
				idx_start = in_xfer;
			end
			bp2l_pkg::ST_INDEX: begin
				ent_re = idx_resp.done;
			end
			bp2l_pkg::ST_ENTRY: begin
				// allocate on a set-branch miss; record the target on an update hit
				if ((func_q == bp2l_pkg::FUNC_SET) && !hit_c) begin
					ent_we           = 1'b1;
					ent_wdata.tag    = pc_q;
				end else if ((func_q == bp2l_pkg::FUNC_UPDATE) && hit_c) begin
					ent_we           = 1'b1;
					ent_wdata.tag    = pc_q;
					ent_wdata.target = target_q;
					ent_wdata.hist   = global_history_q ? ent.hist : hist_next;
				end
				ctr_re = need_ctr;
			end
			bp2l_pkg::ST_COUNTER: begin
				ctr_we = (func_q == bp2l_pkg::FUNC_UPDATE) && row_ok;
			end
			bp2l_pkg::ST_FILL: begin
				// sweep the row: weakly not taken everywhere but the updated counter
				ctr_we    = 1'b1;
				ctr_waddr = {ctr_row_q, fill_q};
				ctr_wdata = (fill_q == ctr_h_q) ? ctr_new_q : bp2l_pkg::CTR_WNT;
			end
			bp2l_pkg::ST_RESULT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= bp2l_pkg::ST_IDLE;
			out_valid_q      <= 1'b0;
			ent_valid_q      <= '0;
			row_valid_q      <= '0;
			shared_hist_q    <= '0;
			global_history_q <= 1'b0;
			global_table_q   <= 1'b0;
			share_index_q    <= 1'b0;
			history_length_q <= bp2l_pkg::HLEN_RESET;
		end else begin
			state_q <= state_d;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (ent_we)
				ent_valid_q[idx_resp.idx] <= 1'b1;

			// drop the counter row of a reallocated entry
			if ((state_q == bp2l_pkg::ST_ENTRY) && (func_q == bp2l_pkg::FUNC_SET) &&
			    !hit_c && !global_table_q)
				row_valid_q[bp2l_pkg::row_t'(idx_resp.idx)] <= 1'b0;
			if ((state_q == bp2l_pkg::ST_FILL) && fill_last)
				row_valid_q[ctr_row_q] <= 1'b1;

			if ((state_q == bp2l_pkg::ST_ENTRY) && (func_q == bp2l_pkg::FUNC_UPDATE) &&
			    hit_c && global_history_q)
				shared_hist_q <= hist_next;

			if (cfg_we) begin
				unique case (bp2l_pkg::cfg_e'(cfg_index))
					bp2l_pkg::CFG_GLOBAL_HISTORY: global_history_q <= cfg_wdata[0];
					bp2l_pkg::CFG_GLOBAL_TABLE:   global_table_q   <= cfg_wdata[0];
					bp2l_pkg::CFG_SHARE_INDEX:    share_index_q    <= cfg_wdata[0];
					bp2l_pkg::CFG_HISTORY_LENGTH: history_length_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q   <= bp2l_pkg::func_e'(func);
			pc_q     <= pc;
			target_q <= target_pc;
			taken_q  <= taken;
		end

		if (state_q == bp2l_pkg::ST_ENTRY) begin
			hit_q        <= hit_c;
			pred_q       <= 1'b0;
			ent_target_q <= ent.target;
			ctr_row_q    <= row_c;
			ctr_h_q      <= h_sample;
		end

		if (state_q == bp2l_pkg::ST_COUNTER) begin
			pred_q    <= ctr_cur[1];
			ctr_new_q <= ctr_upd;
			fill_q    <= '0;
		end

		if (state_q == bp2l_pkg::ST_FILL)
			fill_q <= fill_q + 1'b1;

		if (out_load) begin
			hit_out_q <= hit_q;
			if (func_q == bp2l_pkg::FUNC_PREDICT) begin
				pred_out_q <= pred_q;
				next_pc_q  <= pred_q ? ent_target_q : pc_q + bp2l_pkg::PC_STEP;
			end else begin
				pred_out_q <= 1'b0;
				next_pc_q  <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	// a direct counter write only goes to a row whose contents are valid
	a_ctr_write_row_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctr_we && (state_q == bp2l_pkg::ST_COUNTER)) |-> row_valid_q[ctr_row_q])
		else $error("counter write into an invalid row");

	// no memory write while waiting for an item
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bp2l_pkg::ST_IDLE) |-> (!ent_we && !ctr_we))
		else $error("memory write while idle");

	// the end of a row sweep leaves that row valid
	a_fill_marks_row: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == bp2l_pkg::ST_FILL) && fill_last) |=> row_valid_q[ctr_row_q])
		else $error("row still invalid after sweep");

	// a held result is never overwritten by the next one
	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == bp2l_pkg::ST_RESULT) && out_valid_q && !out_ready) |=>
		(state_q == bp2l_pkg::ST_RESULT))
		else $error("result stage left while output stalled");
`endif

endmodule

/* tb/bp2l_checker.sv */
// Checker for the two-level branch predictor: predicts every result from the input
// transfers and configuration writes it observes, and compares the result channel.
// Depends on bp2l_pkg for sizes, types and function/register codes.
`timescale 1ns / 1ps

module bp2l_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic [bp2l_pkg::PC_W-1:0]  pc,
	input  logic [bp2l_pkg::PC_W-1:0]  target_pc,
	input  logic                       taken,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       hit,
	input  logic                       predict_taken,
	input  logic [bp2l_pkg::PC_W-1:0]  next_pc,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [bp2l_pkg::CFG_W-1:0] cfg_wdata,
	output int                         mismatches,
	output int                         outstanding,
	output int                         results_checked
);

	import bp2l_pkg::*;

	typedef logic [PC_W-1:0] addr_t;

	typedef struct packed {
		addr_t pc;
		logic  hit;
		logic  taken;
		addr_t next;
	} outcome_t;

	outcome_t predicted_outcomes[$];

	addr_t tag_m     [BTB_ENTRIES];
	addr_t target_m  [BTB_ENTRIES];
	hist_t local_hist[BTB_ENTRIES];
	hist_t global_hist;
	ctr_t  row_ctr   [BTB_ENTRIES][ROW_SIZE];
	ctr_t  shared_ctr[ROW_SIZE];

	logic  use_ghist;
	logic  use_gtable;
	logic  fold_index;
	hlen_t hist_len;

	function automatic hist_t len_mask(hlen_t n);
		int bits;
		bits = (n == 0) ? 1 : ((n > HIST_MAX) ? HIST_MAX : int'(n));
		return hist_t'((1 << bits) - 1);
	endfunction

	function automatic hist_t select_hist(int idx);
		hist_t m;
		hist_t h;
		m = len_mask(hist_len);
		h = (use_ghist ? global_hist : local_hist[idx]) & m;
		if (use_gtable && fold_index)
			h = h ^ (hist_t'(idx) & m);
		return h;
	endfunction

	// One step of the buffer: returns the result and updates the shadow state
	function automatic outcome_t advance_btb(func_e f, addr_t p, addr_t tgt, logic tk);
		outcome_t o;
		int       idx;
		hist_t    h;
		hist_t    m;
		ctr_t     c;
		idx     = int'((p >> 2) % BTB_ENTRIES);
		o.pc    = p;
		o.hit   = (tag_m[idx] == p);
		o.taken = 1'b0;
		o.next  = '0;
		case (f)
			FUNC_PREDICT: begin
				o.next = p + PC_STEP;
				if (o.hit) begin
					h = select_hist(idx);
					c = use_gtable ? shared_ctr[h] : row_ctr[idx][h];
					if (c[1]) begin
						o.taken = 1'b1;
						o.next  = target_m[idx];
					end
				end
			end
			FUNC_SET: begin
				if (!o.hit) begin
					tag_m[idx]      = p;
					target_m[idx]   = '0;
					local_hist[idx] = '0;
					if (!use_gtable)
						for (int i = 0; i < ROW_SIZE; i++)
							row_ctr[idx][i] = CTR_WNT;
				end
			end
			FUNC_UPDATE: begin
				if (o.hit) begin
					h = select_hist(idx);
					m = len_mask(hist_len);
					target_m[idx] = tgt;
					if (use_ghist)
						global_hist = hist_t'({global_hist, tk}) & m;
					else
						local_hist[idx] = hist_t'({local_hist[idx], tk}) & m;
					c = use_gtable ? shared_ctr[h] : row_ctr[idx][h];
					if (tk && c != CTR_ST)
						c = c + 2'd1;
					else if (!tk && c != CTR_SNT)
						c = c - 2'd1;
					if (use_gtable)
						shared_ctr[h] = c;
					else
						row_ctr[idx][h] = c;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp;
		outcome_t pred;
		if (!arst_n) begin
			for (int e = 0; e < BTB_ENTRIES; e++) begin
				tag_m[e]      = '0;
				target_m[e]   = '0;
				local_hist[e] = '0;
				for (int i = 0; i < ROW_SIZE; i++)
					row_ctr[e][i] = CTR_WNT;
			end
			for (int i = 0; i < ROW_SIZE; i++)
				shared_ctr[i] = CTR_WNT;
			global_hist = '0;
			use_ghist   = 1'b0;
			use_gtable  = 1'b0;
			fold_index  = 1'b0;
			hist_len    = HLEN_RESET;
			predicted_outcomes.delete();
			mismatches      <= 0;
			outstanding     <= 0;
			results_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_outcomes.size() == 0) begin
					if (mismatches < 10)
						$display("%t: result with nothing pending: hit=%0b taken=%0b next=%h",
							$realtime, hit, predict_taken, next_pc);
					mismatches <= mismatches + 1;
				end else begin
					exp = predicted_outcomes.pop_front();
					if (hit !== exp.hit || predict_taken !== exp.taken ||
					    next_pc !== exp.next) begin
						if (mismatches < 10)
							$display({"%t: pc %h: expected hit=%0b taken=%0b next=%h, ",
								"got hit=%0b taken=%0b next=%h"},
								$realtime, exp.pc, exp.hit, exp.taken, exp.next,
								hit, predict_taken, next_pc);
						mismatches <= mismatches + 1;
					end
					results_checked <= results_checked + 1;
				end
			end
			if (in_valid && in_ready) begin
				pred = advance_btb(func_e'(func), pc, target_pc, taken);
				predicted_outcomes = {predicted_outcomes, pred};
			end
			if (cfg_we) begin
				case (cfg_e'(cfg_index))
					CFG_GLOBAL_HISTORY: use_ghist  = cfg_wdata[0];
					CFG_GLOBAL_TABLE:   use_gtable = cfg_wdata[0];
					CFG_SHARE_INDEX:    fold_index = cfg_wdata[0];
					CFG_HISTORY_LENGTH: hist_len   = hlen_t'(cfg_wdata);
					default: ;
				endcase
			end
			outstanding <= predicted_outcomes.size();
		end
	end

endmodule

/* tb/branch_predictor_btb_two_level_tb.sv */
// Testbench top for the two-level branch predictor: clock, reset, stimulus and verdict.
// Depends on bp2l_pkg, the block itself and bp2l_checker, which does all the checking.
`timescale 1ns / 1ps

module branch_predictor_btb_two_level_tb;

	import bp2l_pkg::*;

	typedef logic [PC_W-1:0] addr_t;

	localparam int POOL_SIZE   = 20;
	localparam int PHASE_ITEMS = 48;
	localparam int HOLD_CYCLES = 200;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        func;
	addr_t             pc;
	addr_t             target_pc;
	logic              taken;
	logic              out_valid;
	logic              out_ready;
	logic              hit;
	logic              predict_taken;
	addr_t             next_pc;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;

	int mismatches;
	int outstanding;
	int results_checked;

	// Idle percentages for each side, changed per phase
	int tx_idle_pct;
	int rx_stall_pct;
	// Set once by the stimulus to ask the receiver for its long hold-off
	bit hold_req;
	int items_sent;
	int phases_run;

	addr_t pc_pool[POOL_SIZE];

	branch_predictor_btb_two_level DUT (.*);

	bp2l_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.pc             (pc),
		.target_pc      (target_pc),
		.taken          (taken),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.predict_taken  (predict_taken),
		.next_pc        (next_pc),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_checked(results_checked)
	);

	// 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: stall at random, or hold off for a long stretch once when asked so the
	// block fills up and backs up its input side.
	initial begin
		bit held;
		held      = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++)
					@(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Offer one item and hold it until the transfer. Enter and leave at a falling edge;
	// valid is left high so a back-to-back item never drops it within one step.
	task automatic send(input func_e f, input addr_t p, input addr_t tgt, input logic tk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		pc        <= p;
		target_pc <= tgt;
		taken     <= tk;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every pending result has been transferred
	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_e r, input logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(negedge clk);
	endtask

	// Write all four registers back to back; only call while the block is idle
	task automatic apply_config(input bit gh, input bit gt, input bit sh, input logic [3:0] hl);
		write_reg(CFG_GLOBAL_HISTORY, {3'b000, gh});
		write_reg(CFG_GLOBAL_TABLE,   {3'b000, gt});
		write_reg(CFG_SHARE_INDEX,    {3'b000, sh});
		write_reg(CFG_HISTORY_LENGTH, hl);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly bursts on one branch from the pool: an optional allocate, then a run of
	// predicts and updates with a biased outcome. One pick in ten is a single item of pure noise.
	task automatic random_items(input int count);
		int    done;
		int    run_len;
		int    bias;
		addr_t p;
		logic  tk;
		done = 0;
		while (done < count) begin
			if ($urandom_range(9) == 0) begin
				send(func_e'($urandom_range(3)), $urandom, $urandom, 1'($urandom_range(1)));
				done++;
			end else begin
				p    = pc_pool[$urandom_range(POOL_SIZE - 1)];
				bias = $urandom_range(2);
				if ($urandom_range(3) == 0) begin
					send(FUNC_SET, p, $urandom, 1'($urandom_range(1)));
					done++;
				end
				run_len = $urandom_range(8, 2);
				repeat (run_len) begin
					case (bias)
						0:       tk = ($urandom_range(9) == 0);
						1:       tk = ($urandom_range(9) != 0);
						default: tk = 1'($urandom_range(1));
					endcase
					send(($urandom_range(2) == 0) ? FUNC_PREDICT : FUNC_UPDATE,
						p, $urandom, tk);
					done++;
				end
			end
		end
	endtask

	// One register setting: wait for the block to go idle, reprogram, pick the idle
	// pattern for this phase, then run random traffic.
	task automatic run_phase(input bit gh, input bit gt, input bit sh, input logic [3:0] hl);
		drain();
		apply_config(gh, gt, sh, hl);
		case (phases_run % 4)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
			default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
		endcase
		// Starve the result side once while the sender keeps pushing
		if (phases_run == 2)
			hold_req = 1'b1;
		random_items(PHASE_ITEMS);
		phases_run++;
	endtask

	initial begin
		addr_t a;
		in_valid     = 1'b0;
		func         = FUNC_PREDICT;
		pc           = '0;
		target_pc    = '0;
		taken        = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_GLOBAL_HISTORY;
		cfg_wdata    = '0;
		arst_n       = 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req     = 1'b0;
		items_sent   = 0;
		phases_run   = 0;

		// Branch pool: twelve distinct buffer slots, then eight that alias the first
		// ones so allocation evicts live entries. A few keep odd low pc bits.
		for (int i = 0; i < POOL_SIZE; i++) begin
			a = $urandom;
			a[6:2] = (i < 12) ? 5'(i * 2 + 1) : 5'((i - 12) * 2 + 1);
			if (i % 5 != 4)
				a[1:0] = 2'b00;
			pc_pool[i] = a;
		end
		pc_pool[0] = 32'h0000_0000;
		pc_pool[1] = 32'hFFFF_FFFC;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset register values, no idling.
		// pc 0 matches every untouched entry since tags come up zero.
		send(FUNC_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);
		send(FUNC_UPDATE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		send(FUNC_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);
		// Unused function code: no state change, only the hit flag
		send(FUNC_NONE,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		// Miss at the top of the address space: fall-through wraps to zero
		send(FUNC_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
		send(FUNC_SET,     32'hFFFF_FFFC, 32'h1234_5678, 1'b1);
		send(FUNC_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
		// Train until the history saturates and its counter flips to taken
		repeat (10)
			send(FUNC_UPDATE, 32'hFFFF_FFFC, 32'hA5A5_A5A4, 1'b1);
		send(FUNC_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
		send(FUNC_UPDATE,  32'hFFFF_FFFC, 32'h5A5A_5A58, 1'b0);
		// Allocate on a hit leaves the entry alone; an aliasing pc evicts it
		send(FUNC_SET,     32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
		send(FUNC_SET,     32'h0000_007C, 32'h0000_0000, 1'b0);
		send(FUNC_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
		send(FUNC_PREDICT, 32'h0000_007C, 32'h0000_0000, 1'b0);

		// Register settings, state carried across: local and global history, per-entry
		// and shared tables, index folding on and off, lengths zero, one, mid, max, over.
		run_phase(1'b0, 1'b0, 1'b0, 4'd8);
		run_phase(1'b1, 1'b0, 1'b0, 4'd4);
		run_phase(1'b0, 1'b1, 1'b0, 4'd8);
		run_phase(1'b0, 1'b1, 1'b1, 4'd8);
		run_phase(1'b1, 1'b1, 1'b1, 4'd3);
		run_phase(1'b1, 1'b1, 1'b0, 4'd1);
		run_phase(1'b0, 1'b0, 1'b1, 4'd0);
		run_phase(1'b1, 1'b1, 1'b1, 4'd15);
		run_phase(1'b0, 1'b1, 1'b1, 4'd2);

		// Let any stray result show up before the verdict
		drain();
		repeat (20) @(negedge clk);

		$display("Covered %0d items: directed corner cases plus %0d register settings",
			items_sent, phases_run);
		$display("Checked %0d results, %0d mismatching", results_checked, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
